/* design/bse_pkg.sv */
package bse_pkg;

    // Number format and index widths.
    localparam int FRAC_BITS  = 28;
    localparam int PIXEL_BITS = 12;
    localparam int VAL_W      = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Coordinate mapping widths: index times step, then origin plus that.
    localparam int PROD_W = PIXEL_BITS + STEP_W;
    localparam int SUM_W  = PROD_W + 2;

    // Scaled product magnitude and the widths of the update arithmetic.
    localparam int MAG_W  = 2 * VAL_W - FRAC_BITS;
    localparam int WIDE_W = (MAG_W > VAL_W) ? MAG_W : VAL_W;
    localparam int UPD_W  = WIDE_W + 3;
    localparam int CMP_W  = (MAG_W + 1 > FRAC_BITS + 3) ? MAG_W + 1 : FRAC_BITS + 3;

    // Escape threshold 4.0 and the largest positive value.
    localparam logic [CMP_W-1:0] FOUR    = CMP_W'(1) << (FRAC_BITS + 2);
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    // Register reset values.
    localparam logic [VAL_W-1:0]  RST_ORIGIN_X = 32'hE000_0000;
    localparam logic [VAL_W-1:0]  RST_ORIGIN_Y = 32'hE000_0000;
    localparam logic [STEP_W-1:0] RST_STEP_X   = 31'd1048576;
    localparam logic [STEP_W-1:0] RST_STEP_Y   = 31'd1048576;
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd64;

    typedef struct packed {
        logic signed [VAL_W-1:0] origin_x;
        logic signed [VAL_W-1:0] origin_y;
        logic [STEP_W-1:0]       step_x;
        logic [STEP_W-1:0]       step_y;
        logic [ITER_W-1:0]       max_iterations;
    } t_cfg;

    typedef struct packed {
        logic [VAL_W-1:0] cx;
        logic [VAL_W-1:0] cy;
    } t_point;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              push;
        logic              pop;
    } t_q_stat;

endpackage

/* design/bse_pix_if.sv */
interface bse_pix_if import bse_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

/* design/bse_res_if.sv */
interface bse_res_if import bse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iteration_count;
    logic              escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink (input valid, input iteration_count, input escaped, output ready);
endinterface

/* design/burning_ship_escape_time_core.sv */
// An accepted pixel passes the coordinate stage register and the queue, then the iteration
// unit; its result is registered and held there until the sink takes it.
// The iteration unit alternates ST_MUL, which forms the three products, and ST_UPD, which
// runs the escape test and the update; it takes a new pixel only from its idle state.
// The coordinate stage and a two-entry queue let new pixels enter while one iterates.
// Reset is synchronous and active low: register defaults return and every stage empties.
module burning_ship_escape_time_core import bse_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bse_pix_if.sink               i_pix,
    bse_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_point  w_front_point;
    logic    w_front_vld;
    logic    w_queue_rdy;
    logic    w_front_busy;
    t_point  w_back_point;
    logic    w_back_vld;
    logic    w_back_rdy;
    t_q_stat w_q_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= RST_ORIGIN_X;
            r_cfg.origin_y       <= RST_ORIGIN_Y;
            r_cfg.step_x         <= RST_STEP_X;
            r_cfg.step_y         <= RST_STEP_Y;
            r_cfg.max_iterations <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_cfg.origin_x       <= i_cfg_data[VAL_W-1:0];
                REG_ORIGIN_Y: r_cfg.origin_y       <= i_cfg_data[VAL_W-1:0];
                REG_STEP_X:   r_cfg.step_x         <= i_cfg_data[STEP_W-1:0];
                REG_STEP_Y:   r_cfg.step_y         <= i_cfg_data[STEP_W-1:0];
                REG_MAX_ITER: r_cfg.max_iterations <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: pixel index to complex point.
    bse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix       (i_pix),
        .o_point     (w_front_point),
        .o_point_vld (w_front_vld),
        .i_point_rdy (w_queue_rdy),
        .o_busy      (w_front_busy)
    );

    // Queue between the two halves.
    bse_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_data (w_front_point),
        .i_push_vld  (w_front_vld),
        .o_push_rdy  (w_queue_rdy),
        .o_pop_data  (w_back_point),
        .o_pop_vld   (w_back_vld),
        .i_pop_rdy   (w_back_rdy),
        .o_stat      (w_q_stat)
    );

    // Back: escape-time iteration.
    bse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_point     (w_back_point),
        .i_point_vld (w_back_vld),
        .o_point_rdy (w_back_rdy),
        .o_res       (o_res)
    );

    // The queue never holds more entries than it has.
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level above its depth");

    // The back only takes a point from a queue that holds one.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.pop |-> (w_q_stat.level != '0))
        else $error("pop from an empty queue");

    // A push alone raises the level by one.
    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.push && !w_q_stat.pop) |=>
            (w_q_stat.level == $past(w_q_stat.level) + QLVL_W'(1)))
        else $error("queue level not raised by a push");

    // An accepted pixel occupies the coordinate stage in the next cycle.
    a_front_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> w_front_busy)
        else $error("accepted pixel lost by the front");

endmodule

/* design/bse_front.sv */
module bse_front import bse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    bse_pix_if.sink   i_pix,
    output t_point    o_point,
    output logic      o_point_vld,
    input  logic      i_point_rdy,
    output logic      o_busy
);

    logic              r_s1_vld;
    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;

    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;

    // Clamp a coordinate to the signed value range.
    function automatic logic [VAL_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'($signed(VAL_MAX));
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return VAL_MAX;
        end else if (v < lo) begin
            return ~VAL_MAX;
        end
        return v[VAL_W-1:0];
    endfunction

    // The stage takes a new transaction when it is empty or drains into the queue.
    assign i_pix.ready = !r_s1_vld || i_point_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    // Index times step, one multiplier per axis.
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_prod_x <= PROD_W'(i_pix.pixel_col) * PROD_W'(i_cfg.step_x);
            r_prod_y <= PROD_W'(i_pix.pixel_row) * PROD_W'(i_cfg.step_y);
        end
    end

    // Origin plus offset, saturated, goes straight to the queue.
    assign w_sum_x = SUM_W'(i_cfg.origin_x) + $signed(SUM_W'(r_prod_x));
    assign w_sum_y = SUM_W'(i_cfg.origin_y) + $signed(SUM_W'(r_prod_y));

    assign o_point.cx  = sat_coord(w_sum_x);
    assign o_point.cy  = sat_coord(w_sum_y);
    assign o_point_vld = r_s1_vld;
    assign o_busy      = r_s1_vld;

endmodule

/* design/bse_queue.sv */
module bse_queue import bse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_point  i_push_data,
    input  logic    i_push_vld,
    output logic    o_push_rdy,
    output t_point  o_pop_data,
    output logic    o_pop_vld,
    input  logic    i_pop_rdy,
    output t_q_stat o_stat
);

    t_point            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    logic w_push;
    logic w_pop;

    assign o_push_rdy = (r_level != QLVL_W'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_level != '0);
    assign w_push     = i_push_vld && o_push_rdy;
    assign w_pop      = i_pop_rdy && o_pop_vld;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (w_pop && !w_push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_stat.level = r_level;
    assign o_stat.push  = w_push;
    assign o_stat.pop   = w_pop;

endmodule

/* design/bse_back.sv */
module bse_back import bse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_point   i_point,
    input  logic     i_point_vld,
    output logic     o_point_rdy,
    bse_res_if.source o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        r_state;
    logic [VAL_W-1:0]  r_x;
    logic [VAL_W-1:0]  r_y;
    logic [VAL_W-1:0]  r_cx;
    logic [VAL_W-1:0]  r_cy;
    logic [ITER_W-1:0] r_cnt;
    logic [MAG_W-1:0]  r_xx;
    logic [MAG_W-1:0]  r_yy;
    logic [MAG_W-1:0]  r_xy_mag;
    logic              r_xy_neg;
    logic              r_out_vld;
    logic [ITER_W-1:0] r_out_cnt;
    logic              r_out_esc;

    logic [VAL_W-1:0]   w_mag_x;
    logic [VAL_W-1:0]   w_mag_y;
    logic [2*VAL_W-1:0] w_pxx;
    logic [2*VAL_W-1:0] w_pyy;
    logic [2*VAL_W-1:0] w_pxy;
    logic [CMP_W-1:0]   w_mag_sum;
    logic               w_esc;
    logic               w_at_limit;
    logic signed [UPD_W-1:0] w_xy_pos;
    logic signed [UPD_W-1:0] w_xy;
    logic signed [UPD_W-1:0] w_nx;
    logic signed [UPD_W-1:0] w_ny;
    logic               w_slot_free;

    // Absolute value, clamped to the largest positive value.
    function automatic logic [VAL_W-1:0] abs_sat(input logic signed [UPD_W-1:0] v);
        logic [UPD_W-1:0] a;
        a = v[UPD_W-1] ? UPD_W'(-v) : UPD_W'(v);
        if (a > UPD_W'(VAL_MAX)) begin
            return VAL_MAX;
        end
        return a[VAL_W-1:0];
    endfunction

    // Magnitudes for the sign-magnitude products.
    assign w_mag_x = r_x[VAL_W-1] ? (~r_x + VAL_W'(1)) : r_x;
    assign w_mag_y = r_y[VAL_W-1] ? (~r_y + VAL_W'(1)) : r_y;
    assign w_pxx   = (2*VAL_W)'(w_mag_x) * (2*VAL_W)'(w_mag_x);
    assign w_pyy   = (2*VAL_W)'(w_mag_y) * (2*VAL_W)'(w_mag_y);
    assign w_pxy   = (2*VAL_W)'(w_mag_x) * (2*VAL_W)'(w_mag_y);

    // Escape test on the registered squares.
    assign w_mag_sum  = CMP_W'(r_xx) + CMP_W'(r_yy);
    assign w_esc      = (w_mag_sum >= FOUR);
    assign w_at_limit = (r_cnt >= i_cfg.max_iterations);

    // Next iterate from the registered products.
    assign w_xy_pos = $signed(UPD_W'(r_xy_mag));
    assign w_xy     = r_xy_neg ? -w_xy_pos : w_xy_pos;
    assign w_nx     = $signed(UPD_W'(r_xx)) - $signed(UPD_W'(r_yy))
                      + UPD_W'($signed(r_cx));
    assign w_ny     = (w_xy <<< 1) + UPD_W'($signed(r_cy));

    assign w_slot_free = !r_out_vld || o_res.ready;
    assign o_point_rdy = (r_state == ST_IDLE);

    // Iteration sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_point_vld) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!w_at_limit) begin
                        r_state <= ST_UPD;
                    end else if (w_slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_UPD: begin
                    if (!w_esc) begin
                        r_state <= ST_MUL;
                    end else if (w_slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_point_vld) begin
                    r_x   <= i_point.cx;
                    r_y   <= i_point.cy;
                    r_cx  <= i_point.cx;
                    r_cy  <= i_point.cy;
                    r_cnt <= '0;
                end
            end
            ST_MUL: begin
                if (!w_at_limit) begin
                    r_xx     <= w_pxx[2*VAL_W-1:FRAC_BITS];
                    r_yy     <= w_pyy[2*VAL_W-1:FRAC_BITS];
                    r_xy_mag <= w_pxy[2*VAL_W-1:FRAC_BITS];
                    r_xy_neg <= r_x[VAL_W-1] ^ r_y[VAL_W-1];
                end
            end
            ST_UPD: begin
                if (!w_esc) begin
                    r_x   <= abs_sat(w_nx);
                    r_y   <= abs_sat(w_ny);
                    r_cnt <= r_cnt + ITER_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: holds a finished count until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_slot_free) begin
            r_out_vld <= ((r_state == ST_MUL) && w_at_limit)
                         || ((r_state == ST_UPD) && w_esc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && (((r_state == ST_MUL) && w_at_limit)
                            || ((r_state == ST_UPD) && w_esc))) begin
            r_out_cnt <= r_cnt;
            r_out_esc <= (r_state == ST_UPD);
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.iteration_count = r_out_cnt;
    assign o_res.escaped         = r_out_esc;

endmodule
